// ----- src/ipcm_pkg.sv -----
// Package for the IPC mailbox endpoint: transfer structs, status codes,
// controller states, ring entry layout and the byte-mask helper.
// No dependencies; every other file in src except ipcm_ram imports it.
package ipcm_pkg;

  // Default number of packets the outbound ring holds.
  localparam int unsigned RingDepthDefault = 8;
  // Largest payload in bytes.
  localparam int unsigned MaxPayload = 6;
  localparam int unsigned PayloadW = 48;

  // Command codes of an input transfer.
  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_SEND    = 2'd1;
  localparam logic [1:0] CMD_RECEIVE = 2'd2;

  // Status codes of a result transfer.
  typedef enum logic [3:0] {
    ST_ENQUEUED  = 4'd0,
    ST_TOO_LONG  = 4'd1,
    ST_FULL      = 4'd2,
    ST_PUBLISHED = 4'd3,
    ST_BUSY      = 4'd4,
    ST_EMPTY     = 4'd5,
    ST_DELIVERED = 4'd6,
    ST_DUPLICATE = 4'd7,
    ST_NONE      = 4'd8
  } ipcm_status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } ipcm_state_e;

  // One input transfer.
  typedef struct packed {
    logic [1:0]          command;
    logic [7:0]          cmd_byte;
    logic [7:0]          length;
    logic [PayloadW-1:0] payload;
    logic                outbound_busy;
    logic                inbound_pending;
    logic [7:0]          in_seq;
    logic [7:0]          in_cmd;
    logic [7:0]          in_length;
    logic [PayloadW-1:0] in_payload;
  } ipcm_req_t;

  // One result transfer.
  typedef struct packed {
    logic [3:0]          status;
    logic [7:0]          seq_out;
    logic [7:0]          cmd_out;
    logic [7:0]          length_out;
    logic [PayloadW-1:0] payload_out;
    logic                ring_doorbell;
    logic                ack_inbound;
    logic                write_ack;
    logic [7:0]          ack_seq;
  } ipcm_res_t;

  // A packet as held in the ring.
  typedef struct packed {
    logic [PayloadW-1:0] payload;
    logic [2:0]          length;
    logic [7:0]          cmd;
  } ipcm_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the accepted transfer and start the ring read
    logic exec;  // evaluate the command and update state
  } ipcm_ctrl_t;

  // Keeps the first n payload bytes and zeroes the rest.
  function automatic logic [PayloadW-1:0] byte_mask(input logic [2:0] n);
    logic [PayloadW-1:0] m;
    m = '0;
    for (int i = 0; i < int'(MaxPayload); i++) begin
      m[8*i +: 8] = (3'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- src/ipcm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ipcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/ipcm_ctrl.sv -----
// Controller of the IPC mailbox endpoint: sequences accept, execute and
// result cycles. Depends on ipcm_pkg.
module ipcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  output ipcm_pkg::ipcm_ctrl_t ctrl_o
);
  import ipcm_pkg::*;

  ipcm_state_e state_q, state_d;
  logic        accept;

  // A transfer is taken whenever the datapath is not executing.
  assign accept = start_i && (state_q != S_EXEC);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  state_d = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = S_RESP;
      S_RESP:  state_d = accept ? S_EXEC : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctrl_o.load = accept;
    ctrl_o.exec = (state_q == S_EXEC);
    busy_o      = (state_q == S_EXEC);
    done_o      = (state_q == S_RESP);
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/ipcm_datapath.sv -----
// Datapath of the IPC mailbox endpoint: input register, outbound ring with
// its indices and fill count, sequence counters and the result register.
// Depends on ipcm_pkg and ipcm_ram.
module ipcm_datapath #(
  parameter int unsigned RingDepth = ipcm_pkg::RingDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ipcm_pkg::ipcm_ctrl_t ctrl_i,
  input  ipcm_pkg::ipcm_req_t  req_i,
  output ipcm_pkg::ipcm_res_t  res_o
);
  import ipcm_pkg::*;

  localparam int unsigned IdxW   = $clog2(RingDepth);
  localparam int unsigned CntW   = $clog2(RingDepth + 1);
  localparam int unsigned EntryW = $bits(ipcm_entry_t);

  ipcm_req_t   req_q;
  ipcm_res_t   res_q, res_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [7:0]  next_seq_q, next_seq_d;
  logic [7:0]  last_seq_q, last_seq_d;
  logic        seen_q, seen_d;
  logic        ram_we;
  ipcm_entry_t wr_entry, rd_entry;
  logic [EntryW-1:0] rd_data;
  logic [2:0]  rx_len;

  // Outbound ring storage.
  ipcm_ram #(
    .Width(EntryW),
    .Depth(RingDepth)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(wr_idx_q),
    .wr_data_i(wr_entry),
    .rd_en_i  (ctrl_i.load),
    .rd_addr_i(rd_idx_q),
    .rd_data_o(rd_data)
  );

  assign rd_entry = ipcm_entry_t'(rd_data);

  // Entry built from the captured enqueue transfer; unused bytes are zeroed.
  always_comb begin
    wr_entry.cmd     = req_q.cmd_byte;
    wr_entry.length  = req_q.length[2:0];
    wr_entry.payload = req_q.payload & byte_mask(req_q.length[2:0]);
  end

  // Inbound length clamped to the largest payload.
  assign rx_len = (req_q.in_length > 8'(MaxPayload)) ? 3'(MaxPayload)
                                                     : req_q.in_length[2:0];

  // Command evaluation during the execute cycle.
  always_comb begin
    res_d      = '0;
    res_d.status = ST_NONE;
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    fill_d     = fill_q;
    next_seq_d = next_seq_q;
    last_seq_d = last_seq_q;
    seen_d     = seen_q;
    ram_we     = 1'b0;
    case (req_q.command)
      CMD_ENQUEUE: begin
        if (req_q.length > 8'(MaxPayload)) begin
          res_d.status = ST_TOO_LONG;
        end else if (fill_q == CntW'(RingDepth)) begin
          res_d.status = ST_FULL;
        end else begin
          res_d.status = ST_ENQUEUED;
          ram_we       = ctrl_i.exec;
          wr_idx_d     = (wr_idx_q == IdxW'(RingDepth - 1)) ? '0 : wr_idx_q + 1'b1;
          fill_d       = fill_q + 1'b1;
        end
      end
      CMD_SEND: begin
        if (req_q.outbound_busy) begin
          res_d.status = ST_BUSY;
        end else if (fill_q == '0) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.status        = ST_PUBLISHED;
          res_d.cmd_out       = rd_entry.cmd;
          res_d.length_out    = {5'd0, rd_entry.length};
          res_d.payload_out   = rd_entry.payload;
          res_d.seq_out       = next_seq_q;
          res_d.ring_doorbell = 1'b1;
          next_seq_d          = next_seq_q + 8'd1;
          rd_idx_d = (rd_idx_q == IdxW'(RingDepth - 1)) ? '0 : rd_idx_q + 1'b1;
          fill_d   = fill_q - 1'b1;
        end
      end
      CMD_RECEIVE: begin
        if (req_q.inbound_pending) begin
          res_d.ack_inbound = 1'b1;
          res_d.write_ack   = 1'b1;
          res_d.ack_seq     = req_q.in_seq;
          if (seen_q && (req_q.in_seq == last_seq_q)) begin
            res_d.status = ST_DUPLICATE;
          end else begin
            res_d.status      = ST_DELIVERED;
            res_d.cmd_out     = req_q.in_cmd;
            res_d.length_out  = {5'd0, rx_len};
            res_d.payload_out = req_q.in_payload & byte_mask(rx_len);
            last_seq_d        = req_q.in_seq;
            seen_d            = 1'b1;
          end
        end
      end
      default: begin
        res_d.status = ST_NONE;
      end
    endcase
  end

  // Input and result registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
    end
    if (ctrl_i.exec) begin
      res_q <= res_d;
    end
  end

  // Ring pointers and sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      fill_q     <= '0;
      next_seq_q <= 8'd1;
      last_seq_q <= 8'd0;
      seen_q     <= 1'b0;
    end else if (ctrl_i.exec) begin
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      fill_q     <= fill_d;
      next_seq_q <= next_seq_d;
      last_seq_q <= last_seq_d;
      seen_q     <= seen_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- src/ipc_mailbox_endpoint_top.sv -----
// Top level of the IPC mailbox endpoint: controller plus datapath.
// Depends on ipcm_pkg, ipcm_ctrl, ipcm_datapath and ipcm_ram.
//
// Usage:
//   A command transfer is taken on a rising edge with start_i high and
//   busy_o low; req_i carries the command (enqueue, send or receive), the
//   packet to enqueue and a snapshot of the mailbox doorbells and the
//   inbound mailbox.
//   Each command gives exactly one result on res_o, shown for one cycle
//   with done_o high, in the result state that follows the execute state.
//   The accepting edge reads the ring entry at the read index (one
//   registered RAM read port); the execute state that follows runs the
//   command, and busy_o is high only then. A new command can be accepted
//   while a result is shown, but not while a command executes.
//   The receiver cannot stall; a result it misses is lost.
//   Reset empties the ring, sets the next outbound sequence to one and
//   forgets the last inbound sequence. Ring contents need no clearing.
module ipc_mailbox_endpoint_top #(
  parameter int unsigned RingDepth = ipcm_pkg::RingDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  ipcm_pkg::ipcm_req_t req_i,
  output logic                done_o,
  output ipcm_pkg::ipcm_res_t res_o
);
  import ipcm_pkg::*;

  ipcm_ctrl_t ctrl;

  // Sequencing.
  ipcm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .ctrl_o (ctrl)
  );

  // Ring, counters and result register.
  ipcm_datapath #(
    .RingDepth(RingDepth)
  ) u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .req_i (req_i),
    .res_o (res_o)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for ipc_mailbox_endpoint_top: drives enqueue, send and
// receive commands and checks every result against its own model of the ring.
// Depends on ipcm_pkg and the RTL under src.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipcm_pkg::*;

  // Command code three has no meaning in the block and must report none.
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandomCommands = 1200;

  // Expected behavior of the mailbox endpoint, and the store of results still owed.
  class mailbox_scoreboard;
    ipcm_entry_t   ring_slots[RingDepthDefault];
    int unsigned   write_slot;
    int unsigned   read_slot;
    int unsigned   packets_held;
    logic [7:0]    next_out_seq;
    logic [7:0]    last_delivered_seq;
    bit            seen_any_seq;
    ipcm_res_t     owed_results[$];
    int unsigned   mismatch_count;

    function new();
      write_slot         = 0;
      read_slot          = 0;
      packets_held       = 0;
      next_out_seq       = 8'd1;
      last_delivered_seq = 8'd0;
      seen_any_seq       = 1'b0;
      mismatch_count     = 0;
    endfunction

    // Keeps the first n payload bytes and clears the rest.
    function logic [PayloadW-1:0] keep_low_bytes(int unsigned n);
      if (n >= MaxPayload) return '1;
      return (PayloadW'(1) << (8 * n)) - PayloadW'(1);
    endfunction

    // Works out the result of an accepted command and updates the model state.
    function void note_command(ipcm_req_t cmd);
      ipcm_res_t   want;
      ipcm_entry_t slot;
      int unsigned clamped;
      want = '0;
      want.status = ST_NONE;
      case (cmd.command)
        CMD_ENQUEUE: begin
          if (cmd.length > 8'(MaxPayload)) begin
            want.status = ST_TOO_LONG;
          end else if (packets_held >= RingDepthDefault) begin
            want.status = ST_FULL;
          end else begin
            slot.cmd     = cmd.cmd_byte;
            slot.length  = cmd.length[2:0];
            slot.payload = cmd.payload & keep_low_bytes(32'(cmd.length));
            ring_slots[write_slot] = slot;
            write_slot   = (write_slot + 1) % RingDepthDefault;
            packets_held = packets_held + 1;
            want.status  = ST_ENQUEUED;
          end
        end
        CMD_SEND: begin
          if (cmd.outbound_busy) begin
            want.status = ST_BUSY;
          end else if (packets_held == 0) begin
            want.status = ST_EMPTY;
          end else begin
            slot = ring_slots[read_slot];
            read_slot          = (read_slot + 1) % RingDepthDefault;
            packets_held       = packets_held - 1;
            want.cmd_out       = slot.cmd;
            want.length_out    = 8'(slot.length);
            want.payload_out   = slot.payload;
            want.seq_out       = next_out_seq;
            next_out_seq       = next_out_seq + 8'd1;
            want.ring_doorbell = 1'b1;
            want.status        = ST_PUBLISHED;
          end
        end
        CMD_RECEIVE: begin
          if (cmd.inbound_pending) begin
            want.ack_inbound = 1'b1;
            want.write_ack   = 1'b1;
            want.ack_seq     = cmd.in_seq;
            if (seen_any_seq && cmd.in_seq == last_delivered_seq) begin
              want.status = ST_DUPLICATE;
            end else begin
              clamped = (cmd.in_length > 8'(MaxPayload)) ? MaxPayload : 32'(cmd.in_length);
              want.cmd_out       = cmd.in_cmd;
              want.length_out    = 8'(clamped);
              want.payload_out   = cmd.in_payload & keep_low_bytes(clamped);
              last_delivered_seq = cmd.in_seq;
              seen_any_seq       = 1'b1;
              want.status        = ST_DELIVERED;
            end
          end
        end
        default: want.status = ST_NONE;
      endcase
      owed_results.push_back(want);
    endfunction

    // Prints one line per mismatch and counts every one.
    function void report_mismatch(string what);
      $display("mismatch: %s", what);
      mismatch_count = mismatch_count + 1;
    endfunction

    function void compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endfunction

    // Compares a result transfer with the oldest result still owed.
    function void check_result(ipcm_res_t got);
      ipcm_res_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("result arrived with no command waiting");
        return;
      end
      want = owed_results.pop_front();
      compare_field("status", 64'(got.status), 64'(want.status));
      compare_field("seq_out", 64'(got.seq_out), 64'(want.seq_out));
      compare_field("cmd_out", 64'(got.cmd_out), 64'(want.cmd_out));
      compare_field("length_out", 64'(got.length_out), 64'(want.length_out));
      compare_field("payload_out", 64'(got.payload_out), 64'(want.payload_out));
      compare_field("ring_doorbell", 64'(got.ring_doorbell), 64'(want.ring_doorbell));
      compare_field("ack_inbound", 64'(got.ack_inbound), 64'(want.ack_inbound));
      compare_field("write_ack", 64'(got.write_ack), 64'(want.write_ack));
      compare_field("ack_seq", 64'(got.ack_seq), 64'(want.ack_seq));
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  ipcm_req_t req_i;
  logic      done_o;
  ipcm_res_t res_o;

  mailbox_scoreboard sb = new();
  int unsigned       stall_cycles = 0;

  ipc_mailbox_endpoint_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Monitor: checks results, records accepted commands and watches for a hang.
  always @(posedge clk_i) begin
    if (done_o) sb.check_result(res_o);
    if (start_i && !busy_o) sb.note_command(req_i);
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Random 48-bit value for a payload field.
  function automatic logic [PayloadW-1:0] random_bytes();
    return PayloadW'({$urandom, $urandom});
  endfunction

  // A command with every field random; callers override what they need.
  function automatic ipcm_req_t base_req(logic [1:0] command);
    ipcm_req_t r;
    r.command         = command;
    r.cmd_byte        = 8'($urandom);
    r.length          = 8'($urandom);
    r.payload         = random_bytes();
    r.outbound_busy   = 1'($urandom);
    r.inbound_pending = 1'($urandom);
    r.in_seq          = 8'($urandom);
    r.in_cmd          = 8'($urandom);
    r.in_length       = 8'($urandom);
    r.in_payload      = random_bytes();
    return r;
  endfunction

  // Mostly well-formed traffic: legal lengths, free doorbell, pending inbound
  // packets, with repeated sequence numbers mixed in.
  function automatic ipcm_req_t random_command();
    ipcm_req_t   r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      r = base_req(CMD_ENQUEUE);
    else if (pick < 75) r = base_req(CMD_SEND);
    else if (pick < 95) r = base_req(CMD_RECEIVE);
    else                r = base_req(CmdUnused);
    if ($urandom_range(0, 99) < 80) r.length = 8'($urandom_range(0, MaxPayload));
    r.outbound_busy   = ($urandom_range(0, 99) < 20);
    r.inbound_pending = ($urandom_range(0, 99) < 80);
    if ($urandom_range(0, 99) < 60) r.in_length = 8'($urandom_range(0, 7));
    if (sb.seen_any_seq && $urandom_range(0, 99) < 30) r.in_seq = sb.last_delivered_seq;
    return r;
  endfunction

  // Presents one command from a falling edge and holds it until the block takes it.
  task automatic issue(ipcm_req_t r);
    req_i   <= r;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Leaves the start line low for a number of cycles.
  task automatic idle_for(int unsigned cycles);
    if (cycles == 0) return;
    start_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  initial begin
    ipcm_req_t   r;
    int unsigned burst_left;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: idle answers, busy before empty, length limits, fill and drain.
    r = base_req(CMD_RECEIVE); r.inbound_pending = 1'b0; issue(r);
    r = base_req(CmdUnused); issue(r);
    r = base_req(CMD_SEND); r.outbound_busy = 1'b0; issue(r);
    r = base_req(CMD_SEND); r.outbound_busy = 1'b1; issue(r);
    r = base_req(CMD_ENQUEUE); r.length = 8'd0; r.cmd_byte = 8'h00; r.payload = '1; issue(r);
    r = base_req(CMD_ENQUEUE); r.length = 8'd6; r.cmd_byte = 8'hFF; r.payload = '1; issue(r);
    r = base_req(CMD_ENQUEUE); r.length = 8'd7; issue(r);
    r = base_req(CMD_ENQUEUE); r.length = 8'd255; issue(r);
    for (int i = 1; i <= 6; i++) begin
      r = base_req(CMD_ENQUEUE); r.length = 8'(i); issue(r);
    end
    // The ring is full now; a too-long packet must still report too long.
    r = base_req(CMD_ENQUEUE); r.length = 8'd3; issue(r);
    r = base_req(CMD_ENQUEUE); r.length = 8'd200; issue(r);
    for (int i = 0; i < int'(RingDepthDefault); i++) begin
      r = base_req(CMD_SEND); r.outbound_busy = 1'b0; issue(r);
    end
    // First delivery with sequence zero, its repeat, then a zero-length packet.
    r = base_req(CMD_RECEIVE); r.inbound_pending = 1'b1; r.in_seq = 8'd0;
    r.in_length = 8'd255; r.in_payload = '1; issue(r);
    r.in_cmd = 8'h5A; issue(r);
    r = base_req(CMD_RECEIVE); r.inbound_pending = 1'b1; r.in_seq = 8'd255;
    r.in_length = 8'd0; issue(r);

    // Random part in bursts separated by random gaps.
    burst_left = $urandom_range(1, 20);
    for (int n = 0; n < int'(RandomCommands); n++) begin
      issue(random_command());
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        idle_for($urandom_range(0, 6));
        burst_left = $urandom_range(1, 20);
      end
    end
    start_i <= 1'b0;

    // Drain, then keep watching for any stray result.
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ipcm_pkg.sv
src/ipcm_ram.sv
src/ipcm_ctrl.sv
src/ipcm_datapath.sv
src/ipc_mailbox_endpoint_top.sv
tb/testbench.sv
